### src/tmh_pkg.sv
// Types and constants shared by the ternary max-heap.
package tmh_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_UP_RD    = 7'b0000010,
    ST_UP_CMP   = 7'b0000100,
    ST_POP_RD   = 7'b0001000,
    ST_POP_LAST = 7'b0010000,
    ST_DN_START = 7'b0100000,
    ST_DN_RD    = 7'b1000000
  } state_t;

endpackage

### src/ternary_max_heap.sv
// Ternary max-heap priority queue over one synchronous key memory.
//
// A command is transferred at a rising edge where start is high and busy is
// low: action selects push (value is the key) or pop of the maximum. The block
// then sifts the heap in its memory and raises done for exactly one cycle;
// top_value, top_valid, entry_count, full_error and empty_error are valid in
// that cycle. The receiver cannot stall, and a new command may be transferred
// in the same cycle that done is high.
// A push into a full heap or a pop of an empty heap raises done with
// full_error or empty_error set and leaves the heap as it was. A push climbs
// level by level, moving each smaller parent down into the hole; a pop reads
// the last key and, unless it was the only one, sifts it down from the root,
// reading up to three children for each slot it visits. Every step is set by
// the single read port of the key memory, whose read data is registered.
// Reset clears the entry count and the control state; the key memory is not
// cleared, since only slots below the entry count are ever read.
module ternary_max_heap
  import tmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action,
  input  logic signed [KEY_W-1:0]  value,
  output logic                     done,
  output logic signed [KEY_W-1:0]  top_value,
  output logic                     top_valid,
  output logic [COUNT_W-1:0]       entry_count,
  output logic                     full_error,
  output logic                     empty_error
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int IW    = AW + 2;
  localparam int RECIP = (2 ** (AW + 1) + 2) / 3;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata;

  state_t                  state, state_next;
  logic [SW-1:0]           size, size_next;
  logic [AW-1:0]           pos, pos_next;
  logic [AW-1:0]           par, par_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic [IW-1:0]           first, first_next;
  logic [1:0]              cnt, cnt_next;
  logic [IW-1:0]           best_idx, best_idx_next;
  logic signed [KEY_W-1:0] best_val, best_val_next;
  logic signed [KEY_W-1:0] root;
  logic                    done_next, full_next, empty_next;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic signed [KEY_W-1:0] wdata;

  logic [AW-1:0]           pos_m1;
  logic [2*AW-1:0]         prod;
  logic [AW-1:0]           par_calc;
  logic [IW-1:0]           first_calc, cand_idx, nxt_idx, size_x;
  logic                    take;
  logic signed [KEY_W-1:0] bv;
  logic [IW-1:0]           bi;

  // Parent (pos-1)/3 through a reciprocal multiply that is exact for AW bits.
  assign pos_m1   = pos - AW'(1);
  assign prod     = {{AW{1'b0}}, pos_m1} * (2 * AW)'(RECIP);
  assign par_calc = AW'(prod >> (AW + 1));

  assign first_calc = {2'b00, pos} + {1'b0, pos, 1'b0} + IW'(1);
  assign size_x     = IW'(size);
  assign cand_idx   = first + IW'(cnt);
  assign nxt_idx    = cand_idx + IW'(1);
  assign take       = (cnt == 2'd0) || (rdata > best_val);
  assign bv         = take ? rdata : best_val;
  assign bi         = take ? cand_idx : best_idx;

  always_comb begin
    state_next    = state;
    size_next     = size;
    pos_next      = pos;
    par_next      = par;
    key_next      = key;
    first_next    = first;
    cnt_next      = cnt;
    best_idx_next = best_idx;
    best_val_next = best_val;
    done_next     = 1'b0;
    full_next     = full_error;
    empty_next    = empty_error;
    we            = 1'b0;
    waddr         = pos;
    wdata         = key;
    raddr         = par_calc;
    case (state)
      ST_IDLE: begin
        if (start) begin
          full_next  = 1'b0;
          empty_next = 1'b0;
          if (action == ACT_PUSH) begin
            if (size >= SW'(CAPACITY)) begin
              full_next = 1'b1;
              done_next = 1'b1;
            end else begin
              key_next   = value;
              pos_next   = AW'(size);
              size_next  = size + SW'(1);
              state_next = ST_UP_RD;
            end
          end else begin
            if (size == '0) begin
              empty_next = 1'b1;
              done_next  = 1'b1;
            end else begin
              state_next = ST_POP_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          raddr      = par_calc;
          par_next   = par_calc;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (key > rdata) begin
          // Move the parent down into the hole and keep climbing.
          wdata      = rdata;
          pos_next   = par;
          state_next = ST_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        raddr      = AW'(size - SW'(1));
        state_next = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        size_next = size - SW'(1);
        if (size == SW'(1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          key_next   = rdata;
          pos_next   = '0;
          state_next = ST_DN_START;
        end
      end
      ST_DN_START: begin
        if (first_calc >= size_x) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          raddr      = AW'(first_calc);
          first_next = first_calc;
          cnt_next   = 2'd0;
          state_next = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        best_val_next = bv;
        best_idx_next = bi;
        if (cnt != 2'd2 && nxt_idx < size_x) begin
          raddr    = AW'(nxt_idx);
          cnt_next = cnt + 2'd1;
        end else if (bv > key) begin
          // The largest child moves up; the hole drops to its slot.
          we         = 1'b1;
          wdata      = bv;
          pos_next   = AW'(bi);
          state_next = ST_DN_START;
        end else begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      size        <= '0;
      done        <= 1'b0;
      full_error  <= 1'b0;
      empty_error <= 1'b0;
    end else begin
      state       <= state_next;
      size        <= size_next;
      done        <= done_next;
      full_error  <= full_next;
      empty_error <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    par      <= par_next;
    key      <= key_next;
    first    <= first_next;
    cnt      <= cnt_next;
    best_idx <= best_idx_next;
    best_val <= best_val_next;
    // A copy of slot zero keeps the maximum on hand without a memory read.
    if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  assign busy        = (state != ST_IDLE);
  assign top_valid   = (size != '0);
  assign top_value   = top_valid ? root : {KEY_W{1'b1}};
  assign entry_count = COUNT_W'(size);

endmodule
